>>> hdl/utf8d_pkg.sv
// Shared types and constants for the legacy UTF-8 stream decoder.
// No dependencies; used by the core, the result queue and the top level.
package utf8d_pkg;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned DUE_W = 3;

    // Lead byte class boundaries
    localparam logic [7:0] LEAD_2B = 8'hE0;
    localparam logic [7:0] LEAD_3B = 8'hF0;
    localparam logic [7:0] LEAD_4B = 8'hF8;
    localparam logic [7:0] LEAD_5B = 8'hFC;
    localparam logic [7:0] LEAD_6B = 8'hFE;

    // Continuation bytes are 10xxxxxx
    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last_of_run;
    } utf8d_result_t;

    // Up to two results raised by one input byte, in order
    typedef struct packed {
        logic [1:0]    count;
        utf8d_result_t first;
        utf8d_result_t second;
    } utf8d_decode_t;

endpackage

>>> hdl/utf8d_core.sv
// Decoder state (payload accumulator, continuation count) and the
// single-pass decode of one byte. Depends on utf8d_pkg.
module utf8d_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [7:0]              byte_in,
    output utf8d_pkg::utf8d_decode_t dec
);
    import utf8d_pkg::*;

    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [DUE_W-1:0] due_reg, due_next;

    // Lead byte decode
    logic             lead_res;
    logic             lead_err;
    logic [CP_W-1:0]  lead_acc;
    logic [DUE_W-1:0] lead_due;
    logic [CP_W-1:0]  cont_acc;
    logic [DUE_W-1:0] cont_due;

    always_comb begin
        lead_res = 1'b0;
        lead_err = 1'b0;
        lead_acc = '0;
        lead_due = '0;
        if (!byte_in[7]) begin
            lead_res = 1'b1;
            lead_acc = {{(CP_W-8){1'b0}}, byte_in};
        end else if (byte_in < LEAD_2B) begin
            lead_acc = {{(CP_W-5){1'b0}}, byte_in[4:0]};
            lead_due = DUE_W'(1);
        end else if (byte_in < LEAD_3B) begin
            lead_acc = {{(CP_W-4){1'b0}}, byte_in[3:0]};
            lead_due = DUE_W'(2);
        end else if (byte_in < LEAD_4B) begin
            lead_acc = {{(CP_W-3){1'b0}}, byte_in[2:0]};
            lead_due = DUE_W'(3);
        end else if (byte_in < LEAD_5B) begin
            lead_acc = {{(CP_W-2){1'b0}}, byte_in[1:0]};
            lead_due = DUE_W'(4);
        end else if (byte_in < LEAD_6B) begin
            lead_acc = {{(CP_W-1){1'b0}}, byte_in[0]};
            lead_due = DUE_W'(5);
        end else begin
            lead_res = 1'b1;
            lead_err = 1'b1;
        end
    end

    assign cont_acc = {acc_reg[CP_W-7:0], byte_in[5:0]};
    assign cont_due = due_reg - DUE_W'(1);

    always_comb begin
        acc_next   = acc_reg;
        due_next   = due_reg;
        dec        = '0;
        if (due_reg != '0) begin
            if (byte_in[7:6] == CONT_TAG) begin
                acc_next = cont_acc;
                due_next = cont_due;
                if (cont_due == '0) begin
                    dec.count             = 2'd1;
                    dec.first.code_point  = cont_acc;
                    dec.first.last_of_run = 1'b1;
                end
            end else begin
                // sequence broken: flag it, then treat the byte as a fresh lead
                acc_next = lead_res ? '0 : lead_acc;
                due_next = lead_due;
                dec.first.is_error = 1'b1;
                if (lead_res) begin
                    dec.count              = 2'd2;
                    dec.second.code_point  = lead_err ? '0 : lead_acc;
                    dec.second.is_error    = lead_err;
                    dec.second.last_of_run = 1'b1;
                end else begin
                    dec.count             = 2'd1;
                    dec.first.last_of_run = 1'b1;
                end
            end
        end else begin
            acc_next = lead_res ? '0 : lead_acc;
            due_next = lead_due;
            if (lead_res) begin
                dec.count             = 2'd1;
                dec.first.code_point  = lead_err ? '0 : lead_acc;
                dec.first.is_error    = lead_err;
                dec.first.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            due_reg <= '0;
        end else if (accept) begin
            acc_reg <= acc_next;
            due_reg <= due_next;
        end
    end

endmodule

>>> hdl/utf8d_out_queue.sv
// Four-entry result queue: takes up to two results per cycle, hands out
// one per cycle while out_ready is high. Depends on utf8d_pkg.
module utf8d_out_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  utf8d_pkg::utf8d_decode_t dec,
    output logic                     room,
    output logic                     out_valid,
    input  logic                     out_ready,
    output utf8d_pkg::utf8d_result_t out_res
);
    import utf8d_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8d_result_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       n_push;
    logic             pop;

    assign n_push    = push ? dec.count : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = entry_reg[rd_ptr_reg];
    // room for the worst case of two results
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entry_reg[wr_ptr_reg] <= dec.first;
        end
        if (n_push == 2'd2) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= dec.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(n_push) - CNT_W'(pop);
        end
    end

endmodule

>>> hdl/utf8_stream_decoder.sv
// Legacy UTF-8 (up to six bytes) to 31-bit code point stream decoder.
// Each result is written into a four-entry result queue when its byte
// is accepted and offered on m_ from there. Throughput: one byte per
// cycle while s_ready is high; the queue absorbs a byte's two results.
// Reset (aresetn low, synchronous) clears the decoder state and empties
// the queue. Depends on utf8d_pkg, utf8d_core and utf8d_out_queue.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_code_point,
    output logic        m_is_error,
    output logic        m_last_of_run
);
    import utf8d_pkg::*;

    logic          accept;
    utf8d_decode_t dec;
    utf8d_result_t res;

    assign accept = s_valid && s_ready;

    utf8d_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .byte_in (s_byte_in),
        .dec     (dec)
    );

    utf8d_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .dec       (dec),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_code_point  = res.code_point;
    assign m_is_error    = res.is_error;
    assign m_last_of_run = res.last_of_run;

endmodule

>>> hdl/utf8d_checker.sv
// Port-level checks for utf8_stream_decoder, attached by bind below.
// No package dependency.
module utf8d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_code_point,
    input logic        m_is_error,
    input logic        m_last_of_run
);

    // nothing left over after reset, and input open again
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("request pending or input blocked after reset");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_error |-> m_code_point == 31'd0)
        else $error("error request carries a non-zero code point");

    // only a broken-sequence error can precede another result of the same byte
    a_nonlast_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_is_error)
        else $error("non-final request is not an error");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point)
            && $stable(m_is_error) && $stable(m_last_of_run))
        else $error("stalled request changed");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_code_point  (m_code_point),
    .m_is_error    (m_is_error),
    .m_last_of_run (m_last_of_run)
);
